>>> src/skfk_pkg.sv
// ----------------------------------------------------------------------------
// skfk_pkg
// Shared types and constants of the skeleton forward kinematics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skfk_pkg;

	// fixed field widths
	localparam int DATA_W   = 32;
	localparam int ROWS     = 4;
	localparam int PROD_W   = 2 * DATA_W;
	// four full products summed exactly
	localparam int ACC_W    = PROD_W + 2;
	localparam int PARENT_W = 7;
	localparam int COL_W    = 2;

	// parent code of a root bone (-1)
	localparam logic [PARENT_W-1:0] ROOT_PARENT = 7'h7F;
	localparam logic [COL_W-1:0]    LAST_COL    = 2'd3;
	localparam logic [COL_W-1:0]    FIRST_COL   = 2'd0;

	// one beat of a column walk through the lanes
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} beat_t;

endpackage

`default_nettype wire

>>> src/skfk_ram.sv
// ----------------------------------------------------------------------------
// skfk_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module skfk_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/skfk_lane.sv
// ----------------------------------------------------------------------------
// skfk_lane
// One row lane: multiplies a parent element by a local element per beat and
// accumulates the four products of one world element exactly.
// ----------------------------------------------------------------------------
`default_nettype none

module skfk_lane (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire skfk_pkg::beat_t                     beat_s2,
	input  wire logic signed [skfk_pkg::DATA_W-1:0]  p_elem,
	input  wire logic signed [skfk_pkg::DATA_W-1:0]  l_elem,
	output logic      signed [skfk_pkg::ACC_W-1:0]   sum_s3
);

	import skfk_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_d;

	// product register
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= p_elem * l_elem;
		end
	end

	// running sum, restarted on the first beat
	always_comb begin
		acc_d = (beat_s2.first ? '0 : acc_q)
			+ {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	end

	always_ff @(posedge clk) begin
		if (en && beat_s2.valid) begin
			acc_q <= acc_d;
			if (beat_s2.last) begin
				sum_s3 <= acc_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/skfk_merge.sv
// ----------------------------------------------------------------------------
// skfk_merge
// Combines the lane sums into one world column: fraction shift with floor,
// saturation to 32 bits, or the local column itself for a root or bad parent.
// ----------------------------------------------------------------------------
`default_nettype none

module skfk_merge #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic signed [skfk_pkg::ACC_W-1:0]                    sum [skfk_pkg::ROWS],
	input  wire logic                                                 mult,
	input  wire logic [skfk_pkg::ROWS-1:0][skfk_pkg::DATA_W-1:0]      loc,
	output logic      [skfk_pkg::ROWS-1:0][skfk_pkg::DATA_W-1:0]      world
);

	import skfk_pkg::*;

	logic signed [ACC_W-1:0]     sh [ROWS];
	logic [ACC_W-DATA_W:0]       top_bits [ROWS];

	// per row: floor shift, range check, select
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			sh[r]       = sum[r] >>> FRAC_BITS;
			top_bits[r] = sh[r][ACC_W-1:DATA_W-1];
			if (!mult) begin
				world[r] = loc[r];
			end else if ((&top_bits[r]) || !(|top_bits[r])) begin
				world[r] = sh[r][DATA_W-1:0];
			end else if (sh[r][ACC_W-1]) begin
				world[r] = {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				world[r] = {1'b0, {(DATA_W-1){1'b1}}};
			end
		end
	end

endmodule

`default_nettype wire

>>> src/skeleton_forward_kinematics_unit.sv
// ----------------------------------------------------------------------------
// skeleton_forward_kinematics_unit
// Streams bone local transforms one column per item and returns the world
// matrix columns of the bone hierarchy in Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

// Each item is one column of a bone's local 4x4 transform plus its parent
// index; each result is the matching world column. A bone that is not a root
// reads its parent's world matrix from the world store one parent column per
// cycle while the result side does not stall; an item holds the four row
// lanes until its last beat is issued, and only then is the next item taken.
// A result passes the issue stage, store read, product register, lane sum
// and output register. When a bone's first column follows right after its
// parent's last column, the new item waits until that column is written back.
// One input item is buffered, so the next item is taken while a result waits
// at the output. The world store holds MAX_BONES matrices and is not cleared:
// parents must have all four columns sent before their children.
module skeleton_forward_kinematics_unit #(
	parameter int MAX_BONES = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// input item channel
	input  wire logic                                  item_valid,
	output logic                                       item_stall,
	input  wire logic                                  start_flag,
	input  wire logic signed [skfk_pkg::PARENT_W-1:0]  parent_bone,
	input  wire logic        [skfk_pkg::COL_W-1:0]     column_index,
	input  wire logic signed [skfk_pkg::DATA_W-1:0]    local_x,
	input  wire logic signed [skfk_pkg::DATA_W-1:0]    local_y,
	input  wire logic signed [skfk_pkg::DATA_W-1:0]    local_z,
	input  wire logic signed [skfk_pkg::DATA_W-1:0]    local_w,
	// result item channel
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output logic        [5:0]                          bone_number,
	output logic        [skfk_pkg::COL_W-1:0]          out_column,
	output logic signed [skfk_pkg::DATA_W-1:0]         world_x,
	output logic signed [skfk_pkg::DATA_W-1:0]         world_y,
	output logic signed [skfk_pkg::DATA_W-1:0]         world_z,
	output logic signed [skfk_pkg::DATA_W-1:0]         world_w,
	output logic                                       bad_parent
);

	import skfk_pkg::*;

	// bone index, bone counter (holds MAX_BONES), store address widths
	localparam int BW  = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int BNW = $clog2(MAX_BONES + 1);
	localparam int AW  = BW + COL_W;
	localparam int CW  = (BNW > 6) ? BNW : 6;
	localparam int DEPTH = (1 << BW) * ROWS;

	typedef struct packed {
		logic [BNW-1:0]                 bone;
		logic [COL_W-1:0]               col;
		logic                           mult;
		logic                           bad;
		logic [BW-1:0]                  parent;
		logic [ROWS-1:0][DATA_W-1:0]    loc;
	} meta_t;

	// input buffer
	logic                            pend_valid_q;
	logic                            pend_start_q;
	logic [PARENT_W-1:0]             pend_parent_q;
	logic [COL_W-1:0]                pend_col_q;
	logic [ROWS-1:0][DATA_W-1:0]     pend_loc_q;

	// issue stage
	logic                            iss_valid_q;
	logic [COL_W-1:0]                iss_k_q;
	meta_t                           iss_q;

	// lane pipeline
	beat_t                           beat_s1;
	beat_t                           beat_s2;
	meta_t                           meta_s1;
	meta_t                           meta_s2;
	meta_t                           meta_s3;
	logic                            s3_valid_q;
	logic signed [DATA_W-1:0]        le_s1;
	logic [ROWS*DATA_W-1:0]          rdata;
	logic signed [ACC_W-1:0]         sum_s3 [ROWS];
	logic [ROWS-1:0][DATA_W-1:0]     world;

	// bone counter and decode of the buffered item
	logic [BNW-1:0]                  cnt_q;
	logic [BNW-1:0]                  bone_new;
	logic [CW-1:0]                   parent_ext;
	logic [BW+5:0]                   parent_wide;
	logic                            is_root;
	logic                            bad_new;
	logic                            mult_new;
	logic                            hazard;
	logic                            take;
	logic                            pipe_en;
	meta_t                           meta_new;

	// store ports
	logic                            we;
	logic [AW-1:0]                   waddr;
	logic [AW-1:0]                   raddr;

	// output register
	logic                            out_valid_q;
	logic [BNW+5:0]                  bone_wide;
	logic [5:0]                      res_bone_q;
	logic [COL_W-1:0]                res_col_q;
	logic [ROWS-1:0][DATA_W-1:0]     res_world_q;
	logic                            res_bad_q;

	assign pipe_en    = !out_valid_q || !result_stall;
	assign item_stall = pend_valid_q;

	// decode of the buffered item against the bone counter
	always_comb begin
		bone_new    = pend_start_q ? '0 : cnt_q;
		parent_ext  = CW'(pend_parent_q[5:0]);
		parent_wide = {{BW{1'b0}}, pend_parent_q[5:0]};
		is_root     = (pend_parent_q == ROOT_PARENT);
		bad_new     = !is_root && (pend_parent_q[PARENT_W-1] || (parent_ext >= CW'(bone_new)));
		mult_new    = !is_root && !bad_new;

		meta_new.bone   = bone_new;
		meta_new.col    = pend_col_q;
		meta_new.mult   = mult_new;
		meta_new.bad    = bad_new;
		meta_new.parent = parent_wide[BW-1:0];
		meta_new.loc    = pend_loc_q;
	end

	// parent columns still on their way to the store
	always_comb begin
		hazard = mult_new && (
			(iss_valid_q   && (parent_ext == CW'(iss_q.bone)))   ||
			(beat_s1.valid && (parent_ext == CW'(meta_s1.bone))) ||
			(beat_s2.valid && (parent_ext == CW'(meta_s2.bone))) ||
			(s3_valid_q    && (parent_ext == CW'(meta_s3.bone))));
		take = pipe_en && pend_valid_q && !hazard
			&& (!iss_valid_q || (iss_k_q == LAST_COL));
	end

	// input buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else begin
			priority if (item_valid && !pend_valid_q) begin
				pend_valid_q <= 1'b1;
			end else if (take) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !pend_valid_q) begin
			pend_start_q  <= start_flag;
			pend_parent_q <= parent_bone;
			pend_col_q    <= column_index;
			pend_loc_q    <= {local_w, local_z, local_y, local_x};
		end
	end

	// issue stage: four beats per item and the bone counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_valid_q <= 1'b0;
			iss_k_q     <= FIRST_COL;
			cnt_q       <= '0;
		end else if (pipe_en) begin
			priority if (take) begin
				iss_valid_q <= 1'b1;
				iss_k_q     <= FIRST_COL;
				if ((pend_col_q == LAST_COL) && (bone_new < BNW'(MAX_BONES))) begin
					cnt_q <= BNW'(bone_new + 1'b1);
				end else begin
					cnt_q <= bone_new;
				end
			end else if (iss_valid_q && (iss_k_q == LAST_COL)) begin
				iss_valid_q <= 1'b0;
			end else if (iss_valid_q) begin
				iss_k_q <= iss_k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			iss_q <= meta_new;
		end
	end

	// parent column k read from the store
	assign raddr = {iss_q.parent, iss_k_q};

	skfk_ram #(
		.WIDTH (ROWS * DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (world),
		.re    (pipe_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// beat control through the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1    <= '0;
			beat_s2    <= '0;
			s3_valid_q <= 1'b0;
		end else if (pipe_en) begin
			beat_s1.valid <= iss_valid_q;
			beat_s1.first <= (iss_k_q == FIRST_COL);
			beat_s1.last  <= (iss_k_q == LAST_COL);
			beat_s2       <= beat_s1;
			s3_valid_q    <= beat_s2.valid && beat_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			le_s1   <= iss_q.loc[iss_k_q];
			meta_s1 <= iss_q;
			meta_s2 <= meta_s1;
			if (beat_s2.valid && beat_s2.last) begin
				meta_s3 <= meta_s2;
			end
		end
	end

	// one lane per world row
	for (genvar r = 0; r < ROWS; r++) begin : g_lane
		skfk_lane u_lane (
			.clk     (clk),
			.en      (pipe_en),
			.beat_s2 (beat_s2),
			.p_elem  (rdata[r*DATA_W +: DATA_W]),
			.l_elem  (le_s1),
			.sum_s3  (sum_s3[r])
		);
	end

	skfk_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.sum   (sum_s3),
		.mult  (meta_s3.mult),
		.loc   (meta_s3.loc),
		.world (world)
	);

	// world column write-back, bones past the store are not kept
	assign we    = pipe_en && s3_valid_q && (meta_s3.bone < BNW'(MAX_BONES));
	assign waddr = {meta_s3.bone[BW-1:0], meta_s3.col};

	// output register
	assign bone_wide = {6'b0, meta_s3.bone};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			out_valid_q <= s3_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en && s3_valid_q) begin
			res_bone_q  <= bone_wide[5:0];
			res_col_q   <= meta_s3.col;
			res_world_q <= world;
			res_bad_q   <= meta_s3.bad;
		end
	end

	assign result_valid = out_valid_q;
	assign bone_number  = res_bone_q;
	assign out_column   = res_col_q;
	assign world_x      = res_world_q[0];
	assign world_y      = res_world_q[1];
	assign world_z      = res_world_q[2];
	assign world_w      = res_world_q[3];
	assign bad_parent   = res_bad_q;

endmodule

`default_nettype wire

>>> tb/sv/skfk_checker.sv
// ----------------------------------------------------------------------------
// skfk_checker
// Watches both item channels of the skeleton forward kinematics unit. Every
// accepted input column is run through a local bone-hierarchy model that
// keeps its own world store and bone counter. The expected world columns are
// queued in order. Every accepted result is compared field by field with the
// oldest queued column.
// ----------------------------------------------------------------------------
module skfk_checker #(
	parameter int MAX_BONES = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	input  logic                                 item_stall,
	input  logic                                 start_flag,
	input  logic        [skfk_pkg::PARENT_W-1:0] parent_bone,
	input  logic        [skfk_pkg::COL_W-1:0]    column_index,
	input  logic        [skfk_pkg::DATA_W-1:0]   local_x,
	input  logic        [skfk_pkg::DATA_W-1:0]   local_y,
	input  logic        [skfk_pkg::DATA_W-1:0]   local_z,
	input  logic        [skfk_pkg::DATA_W-1:0]   local_w,
	input  logic                                 result_valid,
	input  logic                                 result_stall,
	input  logic        [5:0]                    bone_number,
	input  logic        [skfk_pkg::COL_W-1:0]    out_column,
	input  logic        [skfk_pkg::DATA_W-1:0]   world_x,
	input  logic        [skfk_pkg::DATA_W-1:0]   world_y,
	input  logic        [skfk_pkg::DATA_W-1:0]   world_z,
	input  logic        [skfk_pkg::DATA_W-1:0]   world_w,
	input  logic                                 bad_parent,
	output int                                   fail_count,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import skfk_pkg::*;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	typedef logic [ROWS-1:0][DATA_W-1:0] column_t;

	typedef struct packed {
		logic [5:0]       bone;
		logic [COL_W-1:0] col;
		column_t          world;
		logic             bad;
	} world_col_t;

	// model state: world matrices of the first MAX_BONES bones and the running bone index
	logic [DATA_W-1:0] world_mem [MAX_BONES*16];
	int                bone_idx;
	world_col_t        world_due_q [$];

	world_col_t due_col;
	column_t    seen_world;
	string      row_name [ROWS];

	initial begin
		row_name[0] = "world_x";
		row_name[1] = "world_y";
		row_name[2] = "world_z";
		row_name[3] = "world_w";
	end

	// world column of one incoming local column, queued for comparison
	function automatic void compose_world_column(input logic first, input logic [PARENT_W-1:0] parent,
		input logic [COL_W-1:0] col, input column_t loc);
		world_col_t         wc;
		logic signed [65:0] acc, pe, le, sh;
		int                 p, r, k;
		if (first)
			bone_idx = 0;
		p = $signed(parent);
		wc.bone = bone_idx[5:0];
		wc.col = col;
		wc.bad = (parent != ROOT_PARENT) && (p < 0 || p >= bone_idx);
		if (parent == ROOT_PARENT || wc.bad) begin
			wc.world = loc;
		end else begin
			// parent matrix times local column, exact sum, floor shift, clamp
			for (r = 0; r < ROWS; r++) begin
				acc = '0;
				for (k = 0; k < ROWS; k++) begin
					pe = $signed(world_mem[p*16 + k*4 + r]);
					le = $signed(loc[k]);
					acc = acc + pe * le;
				end
				sh = acc >>> FRAC_BITS;
				if (sh > SAT_HI)
					sh = SAT_HI;
				else if (sh < SAT_LO)
					sh = SAT_LO;
				wc.world[r] = sh[DATA_W-1:0];
			end
		end
		// bones past the store are output but not kept
		if (bone_idx < MAX_BONES) begin
			for (r = 0; r < ROWS; r++)
				world_mem[bone_idx*16 + col*4 + r] = wc.world[r];
		end
		if (col == LAST_COL && bone_idx < MAX_BONES)
			bone_idx++;
		world_due_q = {world_due_q, wc};
	endfunction

	// compare results first, then take in new columns
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bone_idx = 0;
			world_due_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (world_due_q.size() == 0) begin
					$error("result item with nothing expected: bone %0d column %0d",
						bone_number, out_column);
					fail_count++;
				end else begin
					due_col = world_due_q.pop_front();
					seen_world = {world_w, world_z, world_y, world_x};
					if (bone_number !== due_col.bone) begin
						$error("bone_number: expected %0d, got %0d", due_col.bone, bone_number);
						fail_count++;
					end
					if (out_column !== due_col.col) begin
						$error("out_column: expected %0d, got %0d", due_col.col, out_column);
						fail_count++;
					end
					for (int r = 0; r < ROWS; r++) begin
						if (seen_world[r] !== due_col.world[r]) begin
							$error("%s: expected %h, got %h", row_name[r], due_col.world[r],
								seen_world[r]);
							fail_count++;
						end
					end
					if (bad_parent !== due_col.bad) begin
						$error("bad_parent: expected %0b, got %0b", due_col.bad, bad_parent);
						fail_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				compose_world_column(start_flag, parent_bone, column_index,
					{local_w, local_z, local_y, local_x});
			pending = world_due_q.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the skeleton forward kinematics unit. A directed
// run covers the saturation extremes, bad parents, skipped columns and a
// restart in mid-frame. Random bone frames follow, mostly well-formed chains
// with random data and some broken bones. One long frame runs the bone
// counter into saturation. Both sides idle at random, and once the result
// side holds off long enough to back the block up. The checker predicts and
// compares.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import skfk_pkg::*;

	localparam int     MAX_BONES      = 64;
	localparam int     FRAC_BITS      = 16;
	localparam int     CLK_PERIOD     = 10;
	localparam int     RESET_CYCLES   = 8;
	localparam int     ITEMS          = 900;
	localparam int     HOLD_CYCLES    = 300;
	localparam int     DRAIN_CYCLES   = 24;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     ROOT_IDX       = -1;

	localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_MONE = 32'hFFFF_0000;
	localparam logic [DATA_W-1:0] Q_NLSB = 32'hFFFF_FFFF;

	typedef logic [ROWS-1:0][DATA_W-1:0] column_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       item_valid;
	logic                       item_stall;
	logic                       start_flag;
	logic signed [PARENT_W-1:0] parent_bone;
	logic        [COL_W-1:0]    column_index;
	logic signed [DATA_W-1:0]   local_x, local_y, local_z, local_w;
	logic                       result_valid;
	logic                       result_stall;
	logic        [5:0]          bone_number;
	logic        [COL_W-1:0]    out_column;
	logic signed [DATA_W-1:0]   world_x, world_y, world_z, world_w;
	logic                       bad_parent;
	int                         fail_count;
	int                         pending;

	// sender-side view of the bone counter and of which columns are stored
	int         gen_bone;
	logic [3:0] cols_written [MAX_BONES];
	int         sent;
	logic       calm;
	logic       hold_req;
	int         quiet_cycles = 0;

	always #(CLK_PERIOD/2) clk = ~clk;

	skeleton_forward_kinematics_unit #(
		.MAX_BONES(MAX_BONES),
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.start_flag(start_flag), .parent_bone(parent_bone), .column_index(column_index),
		.local_x(local_x), .local_y(local_y), .local_z(local_z), .local_w(local_w),
		.result_valid(result_valid), .result_stall(result_stall),
		.bone_number(bone_number), .out_column(out_column),
		.world_x(world_x), .world_y(world_y), .world_z(world_z), .world_w(world_w),
		.bad_parent(bad_parent)
	);

	skfk_checker #(
		.MAX_BONES(MAX_BONES),
		.FRAC_BITS(FRAC_BITS)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.start_flag(start_flag), .parent_bone(parent_bone), .column_index(column_index),
		.local_x(local_x), .local_y(local_y), .local_z(local_z), .local_w(local_w),
		.result_valid(result_valid), .result_stall(result_stall),
		.bone_number(bone_number), .out_column(out_column),
		.world_x(world_x), .world_y(world_y), .world_z(world_z), .world_w(world_w),
		.bad_parent(bad_parent),
		.fail_count(fail_count), .pending(pending)
	);

	// mostly short gaps, a few long ones, none while calm
	function automatic int gap_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DATA_W-1:0] rand_elem();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		// within +/-2.0 keeps chains from saturating at once
		if (pick < 45)
			return DATA_W'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
		if (pick < 80)
			return $urandom;
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return Q_ONE;
			3: return Q_MONE;
			4: return Q_NLSB;
			default: return '0;
		endcase
	endfunction

	function automatic column_t rand_column();
		column_t c;
		for (int r = 0; r < ROWS; r++)
			c[r] = rand_elem();
		return c;
	endfunction

	// a stored bone below the current one, recent bones preferred, or the root
	function automatic int pick_parent(input int eff);
		int p;
		if (eff == 0 || $urandom_range(0, 3) == 0)
			return ROOT_IDX;
		for (int t = 0; t < 6; t++) begin
			p = (t == 0 && $urandom_range(0, 1) == 1) ? eff - 1 : $urandom_range(0, eff - 1);
			if (cols_written[p] == 4'hF)
				return p;
		end
		return ROOT_IDX;
	endfunction

	// negative but not root, or not below the current bone
	function automatic int reject_parent(input int eff);
		if (eff > MAX_BONES - 1 || $urandom_range(0, 1) == 0)
			return -int'($urandom_range(2, 64));
		return $urandom_range(eff, MAX_BONES - 1);
	endfunction

	// offer one column and wait until it is taken
	task automatic send_column(input logic first, input int want_parent,
		input logic [COL_W-1:0] col, input column_t loc);
		int eff;
		int par;
		int gap;
		eff = first ? 0 : gen_bone;
		par = want_parent;
		// never point at a parent with columns that were never stored
		if (par >= 0 && par < eff && cols_written[par] != 4'hF)
			par = ROOT_IDX;
		gap = gap_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		start_flag   <= first;
		parent_bone  <= PARENT_W'(par);
		column_index <= col;
		local_x      <= loc[0];
		local_y      <= loc[1];
		local_z      <= loc[2];
		local_w      <= loc[3];
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		gen_bone = eff;
		if (gen_bone < MAX_BONES)
			cols_written[gen_bone][col] = 1'b1;
		if (col == LAST_COL && gen_bone < MAX_BONES)
			gen_bone++;
		sent++;
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left == 0 && run_left == 0) begin
				stall_left = gap_len();
				run_left = $urandom_range(1, 12);
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
				run_left--;
			end
		end
	end

	// watchdog on cycles where neither channel moves an item
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int   nbones;
		int   eff;
		int   par;
		int   quirk;
		int   cut;
		logic held;
		logic first_frame;
		logic st;

		gen_bone = 0;
		sent = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		held = 1'b0;
		first_frame = 1'b1;
		for (int b = 0; b < MAX_BONES; b++)
			cols_written[b] = '0;

		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		start_flag   <= 1'b0;
		parent_bone  <= '0;
		column_index <= '0;
		local_x      <= '0;
		local_y      <= '0;
		local_z      <= '0;
		local_w      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// root bone holding the extreme values
		send_column(1'b1, ROOT_IDX, 2'd0, {32'h0, Q_ONE, Q_MIN, Q_MAX});
		send_column(1'b0, ROOT_IDX, 2'd1, {Q_ONE, 32'h0, Q_MAX, Q_MIN});
		send_column(1'b0, ROOT_IDX, 2'd2, {Q_MIN, Q_MAX, 32'h0, Q_ONE});
		send_column(1'b0, ROOT_IDX, 2'd3, {Q_MAX, Q_MIN, Q_ONE, 32'h0});
		// child driven into positive and negative clamping and floor rounding
		send_column(1'b0, 0, 2'd0, {Q_MIN, Q_MAX, Q_MIN, Q_MAX});
		send_column(1'b0, 0, 2'd1, {Q_MAX, Q_MIN, Q_MAX, Q_MIN});
		send_column(1'b0, 0, 2'd2, {Q_ONE, 32'h0, 32'h0, 32'h0});
		send_column(1'b0, 0, 2'd3, {32'h1, Q_NLSB, 32'h1, Q_NLSB});
		// rejected parents: negative non-root, self, beyond
		send_column(1'b0, -64, 2'd0, rand_column());
		send_column(1'b0, -2, 2'd1, rand_column());
		send_column(1'b0, 2, 2'd2, rand_column());
		send_column(1'b0, MAX_BONES - 1, 2'd3, rand_column());
		// skipped middle columns
		send_column(1'b0, 2, 2'd0, rand_column());
		send_column(1'b0, 2, 2'd3, rand_column());
		// restart in the middle of a bone
		send_column(1'b0, 1, 2'd0, rand_column());
		send_column(1'b0, 1, 2'd1, rand_column());
		send_column(1'b1, ROOT_IDX, 2'd2, rand_column());
		send_column(1'b0, ROOT_IDX, 2'd3, rand_column());

		// random frames, the first long enough to saturate the bone counter
		while (sent < ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			if (!held && sent >= ITEMS / 2) begin
				held = 1'b1;
				calm = 1'b1;
				hold_req = 1'b1;
			end
			if (first_frame)
				nbones = MAX_BONES + 2;
			else if ($urandom_range(0, 9) == 0)
				nbones = $urandom_range(20, MAX_BONES + 3);
			else
				nbones = $urandom_range(1, 10);
			first_frame = 1'b0;
			for (int b = 0; b < nbones && sent < ITEMS; b++) begin
				quirk = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 4) : 0;
				cut = $urandom_range(0, 3);
				// a stray column with any content
				if (quirk == 4)
					send_column(1'($urandom_range(0, 1)), int'($urandom_range(0, 127)) - 64,
						COL_W'($urandom_range(0, 3)), rand_column());
				eff = (b == 0) ? 0 : gen_bone;
				par = (quirk == 1) ? reject_parent(eff) : pick_parent(eff);
				for (int c = 0; c < ROWS; c++) begin
					st = (b == 0 && c == 0) || (quirk == 3 && c == cut);
					send_column(st, par,
						(quirk == 2) ? COL_W'($urandom_range(0, 3)) : COL_W'(c),
						rand_column());
				end
			end
		end

		item_valid <= 1'b0;
		calm = 1'b0;
		// let the checker count the last item before pending is read
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
src/skfk_pkg.sv
src/skfk_ram.sv
src/skfk_lane.sv
src/skfk_merge.sv
src/skeleton_forward_kinematics_unit.sv
tb/sv/skfk_checker.sv
tb/sv/tb_top.sv
